>>> design/ringtone_text_note_parser_defines.svh
// Assertion macros for the ring-tone text note parser
`ifndef RINGTONE_TEXT_NOTE_PARSER_DEFINES_SVH
`define RINGTONE_TEXT_NOTE_PARSER_DEFINES_SVH

// check that a condition implies a consequence on the same edge
`define RTNP_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// check that a condition implies a consequence on the next edge
`define RTNP_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/rtnp_pkg.sv
// Package: types, constants and tables of the ring-tone text note parser
`timescale 1ns / 1ps
package rtnp_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned LenMsW = 20;
  localparam int unsigned ToneW = 13;

  localparam logic [2:0] ERR_OK = 3'd0;
  localparam logic [2:0] ERR_NO_COLON = 3'd1;
  localparam logic [2:0] ERR_NO_EQ = 3'd2;
  localparam logic [2:0] ERR_DEF_END = 3'd3;
  localparam logic [2:0] ERR_BLANK_END = 3'd4;

  typedef enum logic [3:0] {
    PH_NAME, PH_DEF_START, PH_DEF_EQ, PH_DEF_VAL, PH_DEF_TAIL,
    PH_NOTE_START, PH_NOTE_DUR, PH_T0, PH_T1, PH_T2, PH_T3, PH_T4, PH_T5, PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NOTE, KIND_DONE, KIND_ERR
  } kind_e;

  // one command from front to back
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  err;
    logic        last;
    logic [7:0]  letter;
    logic [4:0]  semi;
    logic [3:0]  octave;
    logic [6:0]  len;
    logic [7:0]  bpm;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_DIV, BK_OUT
  } back_e;

  function automatic logic [12:0] tone_lut(input logic [3:0] idx);
    logic [12:0] v;
    case (idx)
      4'd0: v = 13'd4186;
      4'd1: v = 13'd4434;
      4'd2: v = 13'd4698;
      4'd3: v = 13'd4978;
      4'd4: v = 13'd5274;
      4'd5: v = 13'd5587;
      4'd6: v = 13'd5919;
      4'd7: v = 13'd6271;
      4'd8: v = 13'd6644;
      4'd9: v = 13'd7040;
      4'd10: v = 13'd7458;
      4'd11: v = 13'd7902;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/rtnp_front.sv
// Front end: parse text bytes, emit note, done and error commands
`timescale 1ns / 1ps
module rtnp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [7:0]    text_byte_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output rtnp_pkg::cmd_t cmd_o
);
  import rtnp_pkg::*;

  phase_e     ph_q, ph_d;
  logic [5:0] dlen_q, dlen_d;
  logic [3:0] doct_q, doct_d;
  logic [7:0] bpm_q, bpm_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] setl_q, setl_d;
  logic [6:0] nlen_q, nlen_d;
  logic [4:0] semi_q, semi_d;
  logic [3:0] noct_q, noct_d;
  logic [7:0] plet_q, plet_d;
  logic       blank_q, blank_d;
  logic [7:0] byte_q;
  logic       busy_q, busy_d;
  logic       fire;
  logic       done_byte;
  logic       emit;
  cmd_t       cmd_d;
  logic       done_pend_q, done_pend_d;
  logic       step_ok;

  logic [7:0] b;
  logic       isdig;
  logic [11:0] accx;
  logic [7:0]  accs;
  logic [7:0]  dv;
  logic [5:0]  lenf;
  logic [4:0]  sbase;
  logic [7:0]  lc;

  assign b = byte_q;
  assign isdig = (b >= 8'h30) && (b <= 8'h39);
  assign accx = {4'd0, acc_q} * 12'd10 + {4'd0, b - 8'h30};
  assign accs = (accx > 12'd255) ? 8'd255 : accx[7:0];
  assign dv = (acc_q == 8'd0) ? 8'd1 : acc_q;
  assign lc = b | 8'h20;

  always_comb begin
    if (dv == 8'd1) lenf = 6'd32;
    else if (dv == 8'd2) lenf = 6'd16;
    else if (dv == 8'd3) lenf = 6'd10;
    else if (dv == 8'd4) lenf = 6'd8;
    else if (dv == 8'd5) lenf = 6'd6;
    else if (dv == 8'd6) lenf = 6'd5;
    else if (dv <= 8'd8) lenf = 6'd4;
    else if (dv <= 8'd10) lenf = 6'd3;
    else if (dv <= 8'd16) lenf = 6'd2;
    else if (dv <= 8'd32) lenf = 6'd1;
    else lenf = 6'd0;
  end

  always_comb begin
    case (lc)
      8'h63: sbase = 5'd0;
      8'h64: sbase = 5'd2;
      8'h65: sbase = 5'd4;
      8'h66: sbase = 5'd5;
      8'h67: sbase = 5'd7;
      8'h61: sbase = 5'd9;
      8'h62, 8'h68: sbase = 5'd11;
      default: sbase = 5'd31;
    endcase
  end

  assign full_o = busy_q || done_pend_q;
  assign fire = push_i && !full_o;

  always_comb begin
    ph_d = ph_q; dlen_d = dlen_q; doct_d = doct_q; bpm_d = bpm_q;
    acc_d = acc_q; setl_d = setl_q; nlen_d = nlen_q; semi_d = semi_q;
    noct_d = noct_q; plet_d = plet_q; blank_d = blank_q;
    busy_d = busy_q; emit = 1'b0; done_byte = 1'b0;
    cmd_d = '0;
    cmd_d.kind = KIND_NOTE;
    cmd_d.last = 1'b1;
    if (fire) busy_d = 1'b1;
    if (busy_q) begin
      busy_d = 1'b0;
      unique case (ph_q)
        PH_NAME: begin
          if (b == 8'd0) begin
            emit = 1'b1; cmd_d.kind = KIND_ERR; cmd_d.err = ERR_NO_COLON;
            cmd_d.last = 1'b0; done_byte = 1'b1;
          end else if (b == 8'h3a) ph_d = PH_DEF_START;
        end
        PH_DEF_START: begin
          if (b == 8'd0) begin
            emit = 1'b1; cmd_d.kind = KIND_ERR; cmd_d.err = ERR_DEF_END;
            cmd_d.last = 1'b0; done_byte = 1'b1;
          end else if (b == 8'h3a) begin
            ph_d = PH_NOTE_START; blank_d = 1'b0;
          end else if (b != 8'h20) begin
            setl_d = b; ph_d = PH_DEF_EQ;
          end
        end
        PH_DEF_EQ: begin
          if (b == 8'h3d) begin
            acc_d = '0; ph_d = PH_DEF_VAL;
          end else begin
            emit = 1'b1; cmd_d.kind = KIND_ERR; cmd_d.err = ERR_NO_EQ;
            if (b == 8'd0) begin
              cmd_d.last = 1'b0; done_byte = 1'b1;
            end else ph_d = PH_SKIP;
          end
        end
        PH_DEF_VAL: begin
          if (isdig) acc_d = accs;
          else begin
            if (setl_q == 8'h64) dlen_d = lenf;
            else if (setl_q == 8'h6f) doct_d = (acc_q > 8'd15) ? 4'd15 : acc_q[3:0];
            else if (setl_q == 8'h62) bpm_d = acc_q;
            ph_d = PH_DEF_TAIL; busy_d = 1'b1;
          end
        end
        PH_DEF_TAIL: begin
          if (b == 8'h2c) ph_d = PH_DEF_START;
          else if (b != 8'h20) begin
            ph_d = PH_DEF_START; busy_d = 1'b1;
          end
        end
        PH_NOTE_START: begin
          if (b == 8'd0) begin
            if (blank_q) begin
              emit = 1'b1; cmd_d.kind = KIND_ERR; cmd_d.err = ERR_BLANK_END;
              cmd_d.last = 1'b0;
            end
            done_byte = 1'b1;
          end else if (b == 8'h20) blank_d = 1'b1;
          else if (isdig) begin
            acc_d = b - 8'h30; ph_d = PH_NOTE_DUR;
          end else begin
            plet_d = b; semi_d = sbase; nlen_d = {1'b0, dlen_q};
            noct_d = doct_q; blank_d = 1'b0; ph_d = PH_T0;
          end
        end
        PH_NOTE_DUR: begin
          if (isdig) acc_d = accs;
          else if (b == 8'd0) done_byte = 1'b1;
          else begin
            plet_d = b; semi_d = sbase; nlen_d = {1'b0, lenf};
            noct_d = doct_q; blank_d = 1'b0; ph_d = PH_T0;
          end
        end
        PH_SKIP: begin
          if (b == 8'd0) done_byte = 1'b1;
        end
        PH_T0, PH_T1, PH_T2, PH_T3, PH_T4, PH_T5: begin
          if (b == 8'h23 && ph_q == PH_T0) begin
            semi_d = semi_q + 5'd1; ph_d = PH_T1;
          end else if (b == 8'h62 && (ph_q == PH_T0 || ph_q == PH_T1)) begin
            semi_d = semi_q - 5'd1; ph_d = PH_T2;
          end else if (b == 8'h2e && (ph_q == PH_T0 || ph_q == PH_T1 || ph_q == PH_T2)) begin
            nlen_d = nlen_q + (nlen_q >> 1); ph_d = PH_T3;
          end else if (isdig && ph_q != PH_T4 && ph_q != PH_T5) begin
            noct_d = b[3:0]; ph_d = PH_T4;
          end else if (b == 8'h2e && (ph_q == PH_T3 || ph_q == PH_T4)) begin
            nlen_d = nlen_q + (nlen_q >> 1); ph_d = PH_T5;
          end else if (b == 8'h20) ph_d = PH_T5;
          else begin
            emit = 1'b1;
            cmd_d.kind = KIND_NOTE;
            cmd_d.letter = plet_q; cmd_d.semi = semi_q; cmd_d.octave = noct_q;
            cmd_d.len = nlen_q; cmd_d.bpm = bpm_q;
            cmd_d.last = (b != 8'd0);
            ph_d = PH_NOTE_START; blank_d = 1'b0;
            if (b != 8'h2c) busy_d = 1'b1;
          end
        end
        default: begin
          ph_d = PH_NAME; busy_d = 1'b1;
        end
      endcase
      if (done_byte) begin
        ph_d = PH_NAME; blank_d = 1'b0;
      end
      // hold the step while the queue is full
      if ((emit || done_byte) && !cmd_ready_i) begin
        ph_d = ph_q; dlen_d = dlen_q; doct_d = doct_q; bpm_d = bpm_q;
        acc_d = acc_q; setl_d = setl_q; nlen_d = nlen_q; semi_d = semi_q;
        noct_d = noct_q; plet_d = plet_q; blank_d = blank_q; busy_d = 1'b1;
      end
    end
  end

  // a done after an error is registered in done_pend and offered until the queue takes it
  always_comb begin
    done_pend_d = done_pend_q;
    cmd_valid_o = 1'b0;
    cmd_o = cmd_d;
    if (done_pend_q) begin
      cmd_valid_o = 1'b1;
      cmd_o = '0;
      cmd_o.kind = KIND_DONE;
      cmd_o.last = 1'b1;
      if (cmd_ready_i) done_pend_d = 1'b0;
    end else if (busy_q && emit) begin
      cmd_valid_o = 1'b1;
      if (cmd_ready_i && done_byte) done_pend_d = 1'b1;
    end else if (busy_q && done_byte) begin
      cmd_valid_o = 1'b1;
      cmd_o = '0;
      cmd_o.kind = KIND_DONE;
      cmd_o.last = 1'b1;
    end
  end

  assign step_ok = !done_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_NAME; dlen_q <= 6'd4; doct_q <= 4'd6; bpm_q <= 8'd63;
      acc_q <= '0; setl_q <= '0; nlen_q <= '0; semi_q <= 5'd31;
      noct_q <= '0; plet_q <= '0; blank_q <= 1'b0; busy_q <= 1'b0;
      done_pend_q <= 1'b0;
    end else begin
      done_pend_q <= done_pend_d;
      if (step_ok) begin
        ph_q <= ph_d; dlen_q <= dlen_d; doct_q <= doct_d; bpm_q <= bpm_d;
        acc_q <= acc_d; setl_q <= setl_d; nlen_q <= nlen_d; semi_q <= semi_d;
        noct_q <= noct_d; plet_q <= plet_d; blank_q <= blank_d; busy_q <= busy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) byte_q <= text_byte_i;
  end

endmodule

>>> design/rtnp_queue.sv
// Short command queue between front and back
`timescale 1ns / 1ps
module rtnp_queue #(
  parameter int unsigned Depth = rtnp_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  rtnp_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output rtnp_pkg::cmd_t rd_data_o
);
  import rtnp_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != (AW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

>>> design/rtnp_back.sv
// Back end: tone lookup, iterative length divide, result register
`timescale 1ns / 1ps
`include "ringtone_text_note_parser_defines.svh"
module rtnp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  rtnp_pkg::cmd_t cmd_i,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [7:0]     note_letter_o,
  output logic [12:0]    tone_hz_o,
  output logic [19:0]    length_ms_o,
  output logic           song_done_o,
  output logic [2:0]     error_code_o,
  output logic           last_of_run_o
);
  import rtnp_pkg::*;

  back_e st_q, st_d;
  logic [22:0] num_q;
  logic [12:0] den_q;
  logic [22:0] rem_q;
  logic [4:0]  cnt_q;
  logic [7:0]  let_q;
  logic [12:0] tone_q;
  logic [2:0]  err_q;
  logic        done_q, last_q;
  logic [23:0] trial;
  logic        load, step, take;
  logic [4:0]  q12;
  logic [3:0]  r12;
  logic [3:0]  sh;
  logic [12:0] tone_c;
  logic [7:0]  bpm1;

  always_comb begin
    if (cmd_i.semi[4]) begin
      q12 = {1'b0, cmd_i.octave};
      r12 = 4'(cmd_i.semi + 5'd12);
    end else if (cmd_i.semi >= 5'd12) begin
      q12 = {1'b0, cmd_i.octave} + 5'd2;
      r12 = 4'(cmd_i.semi - 5'd12);
    end else begin
      q12 = {1'b0, cmd_i.octave} + 5'd1;
      r12 = cmd_i.semi[3:0];
    end
    sh = (q12 >= 5'd9) ? 4'd0 : 4'(5'd9 - q12);
    tone_c = (cmd_i.semi == 5'd31) ? 13'd0 : (tone_lut(r12) >> sh);
  end

  assign bpm1 = (cmd_i.bpm == 8'd0) ? 8'd1 : cmd_i.bpm;
  assign trial = {rem_q, num_q[22]} - {11'd0, den_q};

  always_comb begin
    st_d = st_q; load = 1'b0; step = 1'b0; take = 1'b0;
    unique case (st_q)
      BK_IDLE: if (cmd_valid_i) begin
        load = 1'b1;
        st_d = (cmd_i.kind == KIND_NOTE) ? BK_DIV : BK_OUT;
      end
      BK_DIV: begin
        step = 1'b1;
        if (cnt_q == 5'd22) st_d = BK_OUT;
      end
      BK_OUT: if (pop_i) begin
        take = 1'b1; st_d = BK_IDLE;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  assign cmd_ready_o = (st_q == BK_IDLE);
  assign empty_o = (st_q != BK_OUT);
  assign note_letter_o = let_q;
  assign tone_hz_o = tone_q;
  assign length_ms_o = num_q[19:0];
  assign song_done_o = done_q;
  assign error_code_o = err_q;
  assign last_of_run_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (load) cnt_q <= '0;
      else if (step) cnt_q <= cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      let_q <= cmd_i.letter;
      err_q <= cmd_i.err;
      done_q <= (cmd_i.kind == KIND_DONE);
      last_q <= cmd_i.last;
      rem_q <= '0;
      den_q <= {bpm1, 3'd0};
      if (cmd_i.kind == KIND_NOTE) begin
        tone_q <= tone_c;
        num_q <= 23'(cmd_i.len * 23'd60000);
      end else begin
        tone_q <= '0;
        num_q <= '0;
      end
    end else if (step) begin
      if (!trial[23]) begin
        rem_q <= trial[22:0];
        num_q <= {num_q[21:0], 1'b1};
      end else begin
        rem_q <= {rem_q[21:0], num_q[22]};
        num_q <= {num_q[21:0], 1'b0};
      end
    end
  end

  `RTNP_ASSERT_IMP(a_no_load_busy, clk_i, rst_ni, st_q != BK_IDLE, !load)
  `RTNP_ASSERT_NEXT(a_div_ends, clk_i, rst_ni, st_q == BK_DIV && cnt_q == 5'd22, st_q == BK_OUT)
  `RTNP_ASSERT_IMP(a_done_clean, clk_i, rst_ni, !empty_o && song_done_o, tone_hz_o == 13'd0)

endmodule

>>> design/ringtone_text_note_parser.sv
// Top level: ring-tone text note parser
`timescale 1ns / 1ps
// Channel   Handshake        Payload
// input     push / full      text_byte_i
// result    empty / pop      note_letter_o tone_hz_o length_ms_o song_done_o
//                            error_code_o last_of_run_o
// A byte is held in the front while it is handled; a byte that ends a value, or a definition
// or note without a comma, is handled again in the new phase, and the front holds while a
// done word that follows an error waits. A note word is ready after a 23-step restoring
// divider; other words skip it. The back is ready again in the cycle after a pop.
// Reset clears all control state; defaults persist across songs. The 4-entry queue
// lets the front parse while the back divides; the front stalls while it is full.
module ringtone_text_note_parser #(
  parameter int unsigned QDepth = rtnp_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  note_letter_o,
  output logic [12:0] tone_hz_o,
  output logic [19:0] length_ms_o,
  output logic        song_done_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_run_o
);
  import rtnp_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  rtnp_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .text_byte_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  rtnp_queue #(.Depth(QDepth)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_cmd),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_cmd)
  );

  rtnp_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .empty_o(empty), .pop_i(pop), .note_letter_o, .tone_hz_o, .length_ms_o,
    .song_done_o, .error_code_o, .last_of_run_o
  );

endmodule

>>> dv/ringtone_text_note_parser_test.sv
// Testbench for the ring-tone text note parser: song text in, predicted note results checked out
`timescale 1ns / 1ps
module ringtone_text_note_parser_test;
  import rtnp_pkg::*;

  typedef struct packed {
    logic [7:0]  letter;
    logic [12:0] tone;
    logic [19:0] ms;
    logic        done;
    logic [2:0]  err;
    logic        last;
  } note_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  text_byte_i = 8'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  note_letter_o;
  logic [12:0] tone_hz_o;
  logic [19:0] length_ms_o;
  logic        song_done_o;
  logic [2:0]  error_code_o;
  logic        last_of_run_o;

  ringtone_text_note_parser dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .text_byte_i(text_byte_i),
    .empty(empty), .pop(pop), .note_letter_o(note_letter_o), .tone_hz_o(tone_hz_o),
    .length_ms_o(length_ms_o), .song_done_o(song_done_o), .error_code_o(error_code_o),
    .last_of_run_o(last_of_run_o)
  );

  always #6 clk_i = ~clk_i;

  logic [7:0]  text_queue[$];
  note_word_t  notes_due[$];
  note_word_t  batch[$];
  int          errors = 0;
  bit          byte_taken = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          calm = 1'b0;
  int          sent = 0;

  // parser state of the song being followed
  phase_e      ph = PH_NAME;
  logic [6:0]  dflt_len = 7'd4;
  logic [3:0]  dflt_oct = 4'd6;
  logic [7:0]  bpm = 8'd63;
  logic [7:0]  accum = 8'd0;
  logic [7:0]  set_letter = 8'd0;
  logic [6:0]  nlen = 7'd0;
  logic [4:0]  nsemi = 5'd31;
  logic [3:0]  noct = 4'd0;
  logic [7:0]  nletter = 8'd0;
  logic        blank = 1'b0;

  int unsigned tones[12] = '{4186, 4434, 4698, 4978, 5274, 5587,
                             5919, 6271, 6644, 7040, 7458, 7902};

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [6:0] len_of(logic [7:0] v);
    return 7'(32 / (v == 0 ? 1 : v));
  endfunction

  task automatic emit(logic [7:0] l, logic [12:0] t, logic [19:0] m, logic d, logic [2:0] e);
    note_word_t w;
    w = '{l, t, m, d, e, 1'b0};
    batch.push_back(w);
  endtask

  task automatic end_song();
    emit(8'd0, 13'd0, 20'd0, 1'b1, ERR_OK);
    ph = PH_NAME;
    blank = 1'b0;
  endtask

  task automatic add_digit(logic [7:0] b);
    int unsigned v;
    v = accum * 10 + (b - "0");
    accum = v > 255 ? 8'd255 : 8'(v);
  endtask

  task automatic open_note(logic [7:0] b, logic [6:0] len);
    logic [7:0] c;
    int s;
    c = b | 8'h20;
    case (c)
      "c": s = 0;
      "d": s = 2;
      "e": s = 4;
      "f": s = 5;
      "g": s = 7;
      "a": s = 9;
      "b", "h": s = 11;
      default: s = -1;
    endcase
    nletter = b;
    nsemi = 5'(s);
    nlen = len;
    noct = dflt_oct;
    blank = 1'b0;
    ph = PH_T0;
  endtask

  task automatic close_note();
    int semi;
    int unsigned t, q, sh, tone, ms, div;
    semi = nsemi[4] ? int'(nsemi) - 32 : int'(nsemi);
    div = (bpm == 0 ? 1 : bpm) * 8;
    ms = (nlen * 60000) / div;
    tone = 0;
    if (semi != -1) begin
      t = (noct + 1) * 12 + semi;
      q = t / 12;
      sh = q >= 9 ? 0 : 9 - q;
      tone = tones[t % 12] >> sh;
    end
    emit(nletter, 13'(tone), 20'(ms), 1'b0, ERR_OK);
    ph = PH_NOTE_START;
    blank = 1'b0;
  endtask

  task automatic predict_byte(logic [7:0] b);
    bit redo;
    int s;
    batch.delete();
    redo = 1'b1;
    while (redo) begin
      redo = 1'b0;
      if (ph >= PH_T0 && ph <= PH_T5) begin
        s = int'(ph) - int'(PH_T0);
        if (b == "#" && s == 0) begin
          nsemi = nsemi + 5'd1;
          ph = PH_T1;
        end else if (b == "b" && s <= 1) begin
          nsemi = nsemi - 5'd1;
          ph = PH_T2;
        end else if (b == "." && s <= 2) begin
          nlen = nlen + nlen / 2;
          ph = PH_T3;
        end else if (is_num(b) && s <= 3) begin
          noct = 4'(b - "0");
          ph = PH_T4;
        end else if (b == "." && s <= 4) begin
          nlen = nlen + nlen / 2;
          ph = PH_T5;
        end else if (b == " ") begin
          ph = PH_T5;
        end else begin
          close_note();
          redo = b != ",";
        end
      end else begin
        case (ph)
          PH_NAME: begin
            if (b == 0) begin
              emit(8'd0, 13'd0, 20'd0, 1'b0, ERR_NO_COLON);
              end_song();
            end else if (b == ":") ph = PH_DEF_START;
          end
          PH_DEF_START: begin
            if (b == 0) begin
              emit(8'd0, 13'd0, 20'd0, 1'b0, ERR_DEF_END);
              end_song();
            end else if (b == ":") begin
              ph = PH_NOTE_START;
              blank = 1'b0;
            end else if (b != " ") begin
              set_letter = b;
              ph = PH_DEF_EQ;
            end
          end
          PH_DEF_EQ: begin
            if (b == "=") begin
              accum = 8'd0;
              ph = PH_DEF_VAL;
            end else begin
              emit(8'd0, 13'd0, 20'd0, 1'b0, ERR_NO_EQ);
              if (b == 0) end_song();
              else ph = PH_SKIP;
            end
          end
          PH_DEF_VAL: begin
            if (is_num(b)) add_digit(b);
            else begin
              if (set_letter == "d") dflt_len = len_of(accum);
              else if (set_letter == "o") dflt_oct = accum > 15 ? 4'd15 : 4'(accum);
              else if (set_letter == "b") bpm = accum;
              ph = PH_DEF_TAIL;
              redo = 1'b1;
            end
          end
          PH_DEF_TAIL: begin
            if (b == ",") ph = PH_DEF_START;
            else if (b != " ") begin
              ph = PH_DEF_START;
              redo = 1'b1;
            end
          end
          PH_NOTE_START: begin
            if (b == 0) begin
              if (blank) emit(8'd0, 13'd0, 20'd0, 1'b0, ERR_BLANK_END);
              end_song();
            end else if (b == " ") blank = 1'b1;
            else if (is_num(b)) begin
              accum = 8'(b - "0");
              ph = PH_NOTE_DUR;
            end else open_note(b, dflt_len);
          end
          PH_NOTE_DUR: begin
            if (is_num(b)) add_digit(b);
            else if (b == 0) end_song();
            else open_note(b, len_of(accum));
          end
          PH_SKIP: if (b == 0) end_song();
          default: begin
            ph = PH_NAME;
            redo = 1'b1;
          end
        endcase
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) notes_due.push_back(batch[i]);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_queue.push_back(s[i]);
  endtask

  task automatic add_num(int unsigned v);
    add_text($sformatf("%0d", v));
  endtask

  function automatic int unsigned pick_value();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1 << $urandom_range(0, 5);
      2: return $urandom_range(0, 999);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic add_song();
    string letters;
    letters = "cdefgabhpCDEFGABHPxz";
    repeat ($urandom_range(0, 5)) text_queue.push_back(8'($urandom_range("a", "z")));
    text_queue.push_back(":");
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) add_text(" ");
      case ($urandom_range(0, 4))
        0: add_text("d=");
        1: add_text("o=");
        2, 3: add_text("b=");
        default: add_text("q=");
      endcase
      add_num($urandom_range(0, 1) ? pick_value() : $urandom_range(30, 250));
      if ($urandom_range(0, 3) == 0) add_text(" ");
      add_text(",");
    end
    text_queue.push_back(":");
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 4) == 0) add_text(" ");
      if ($urandom_range(0, 1)) add_num(pick_value());
      text_queue.push_back(letters[$urandom_range(0, letters.len() - 1)]);
      if ($urandom_range(0, 3) == 0) add_text("#");
      if ($urandom_range(0, 3) == 0) add_text("b");
      if ($urandom_range(0, 3) == 0) add_text(".");
      if ($urandom_range(0, 1)) add_num($urandom_range(0, 9));
      if ($urandom_range(0, 3) == 0) add_text(".");
      if ($urandom_range(0, 4) == 0) add_text(" ");
      if ($urandom_range(0, 9) == 0) text_queue.push_back(8'($urandom_range(0, 255)));
      add_text(",");
    end
    if ($urandom_range(0, 1)) text_queue.pop_back();
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 6)) text_queue.push_back(8'($urandom_range(1, 255)));
    text_queue.push_back(8'd0);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    string directed[$];
    directed = '{"ab", ":", ":d5x", ":d=4", "::  ", "::8", "::c",
                 ":d=0,o=20,b=0:c,p#,4b#b.5.,32H.9.,e#3",
                 ": d=32 , q=7,b=255:2A.15,,999g,z, C#b.0.",
                 ":o=3,b=999:1cb0.,16f#b.8. ,c , ",
                 ":d=1,o=15,b=1:c9,b8.", "x:o=0,b=63,d=4:p,1c.,h9"};
    foreach (directed[i]) begin
      add_text(directed[i]);
      text_queue.push_back(8'd0);
    end
    text_queue.push_back(8'hFF);
    text_queue.push_back(8'd0);
    while (text_queue.size() < 900) add_song();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sent % 200 == 150) calm <= ~calm;
      if (!push || byte_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          push <= 1'b0;
        end else if (text_queue.size() > 0) begin
          text_byte_i <= text_queue.pop_front();
          push <= 1'b1;
          send_gap <= pick_gap();
          sent <= sent + 1;
        end else begin
          push <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    note_word_t w;
    byte_taken <= push && !full;
    if (rst_ni && push && !full) predict_byte(text_byte_i);
    if (rst_ni && pop && !empty) begin
      if (notes_due.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        w = notes_due.pop_front();
        if (note_letter_o !== w.letter) begin
          $error("note_letter expected %0h got %0h", w.letter, note_letter_o);
          errors++;
        end
        if (tone_hz_o !== w.tone) begin
          $error("tone_hz expected %0d got %0d", w.tone, tone_hz_o);
          errors++;
        end
        if (length_ms_o !== w.ms) begin
          $error("length_ms expected %0d got %0d", w.ms, length_ms_o);
          errors++;
        end
        if (song_done_o !== w.done) begin
          $error("song_done expected %0d got %0d", w.done, song_done_o);
          errors++;
        end
        if (error_code_o !== w.err) begin
          $error("error_code expected %0d got %0d", w.err, error_code_o);
          errors++;
        end
        if (last_of_run_o !== w.last) begin
          $error("last_of_run expected %0d got %0d", w.last, last_of_run_o);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (text_queue.size() == 0 && !push);
    wait (notes_due.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && notes_due.size() == 0) begin
      $display("ringtone_text_note_parser test passed");
    end else begin
      $display("ringtone_text_note_parser test failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("ringtone_text_note_parser test failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/rtnp_pkg.sv
design/rtnp_front.sv
design/rtnp_queue.sv
design/rtnp_back.sv
design/ringtone_text_note_parser.sv
dv/ringtone_text_note_parser_test.sv
